/* hw/rtl/iir3_pkg.sv */
// Shared widths, constants and register codes for the third-order IIR filter.
package iir3_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 24;
   localparam int COEF_FRAC_BITS = 20;
   localparam int NUM_COEFS      = 7;
   localparam int ORDER          = 3;
   localparam int CSR_INDEX_BITS = $clog2(NUM_COEFS + 1);

   // Full-precision product and the sum of all seven products
   localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS   = PROD_BITS + $clog2(NUM_COEFS);
   localparam int QUOT_BITS  = ACC_BITS - COEF_FRAC_BITS;

   localparam int SAMPLE_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
   localparam int SAMPLE_MIN = -(1 << (SAMPLE_BITS - 1));

   localparam logic signed [COEF_BITS-1:0] COEF_UNITY = COEF_BITS'(1 << COEF_FRAC_BITS);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      COEF_INPUT_NOW    = CSR_INDEX_BITS'(0),
      COEF_INPUT_PREV1  = CSR_INDEX_BITS'(1),
      COEF_INPUT_PREV2  = CSR_INDEX_BITS'(2),
      COEF_INPUT_PREV3  = CSR_INDEX_BITS'(3),
      COEF_OUTPUT_PREV1 = CSR_INDEX_BITS'(4),
      COEF_OUTPUT_PREV2 = CSR_INDEX_BITS'(5),
      COEF_OUTPUT_PREV3 = CSR_INDEX_BITS'(6)
   } coef_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;

endpackage

/* hw/rtl/iir3_tap_cell.sv */
// One delay tap of the filter: holds a past sample and weights it by its coefficient.
module iir3_tap_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  iir3_pkg::sample_type tap_in,
   input  iir3_pkg::coef_type   coef,
   output iir3_pkg::sample_type tap_out,
   output iir3_pkg::prod_type   product
);

   iir3_pkg::sample_type tap_ff;
   iir3_pkg::sample_type tap_next_in;

   assign tap_next_in = advance ? tap_in : tap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_next_in;
      end
   end

   assign tap_out = tap_ff;
   assign product = iir3_pkg::PROD_BITS'(tap_ff) * iir3_pkg::PROD_BITS'(coef);

endmodule

/* hw/rtl/iir3_accum.sv */
// Feed-forward minus feedback, rounded to nearest, saturated to sample width.
module iir3_accum (
   input  iir3_pkg::prod_type   ff_product [iir3_pkg::ORDER+1],
   input  iir3_pkg::prod_type   fb_product [iir3_pkg::ORDER],
   output iir3_pkg::sample_type sample,
   output logic                 clipped
);

   logic signed [iir3_pkg::ACC_BITS-1:0]  acc;
   logic signed [iir3_pkg::ACC_BITS-1:0]  rounded;
   logic signed [iir3_pkg::QUOT_BITS-1:0] quot;
   logic                                  over;
   logic                                  under;

   always_comb begin
      acc = '0;
      for (int i = 0; i <= iir3_pkg::ORDER; i++) begin
         acc = acc + iir3_pkg::ACC_BITS'(ff_product[i]);
      end
      for (int i = 0; i < iir3_pkg::ORDER; i++) begin
         acc = acc - iir3_pkg::ACC_BITS'(fb_product[i]);
      end
   end

   // Add half an LSB, then floor shift: ties go toward plus infinity
   assign rounded = acc + iir3_pkg::ACC_BITS'(1 << (iir3_pkg::COEF_FRAC_BITS - 1));
   assign quot    = iir3_pkg::QUOT_BITS'(rounded >>> iir3_pkg::COEF_FRAC_BITS);

   assign over  = quot > iir3_pkg::QUOT_BITS'(iir3_pkg::SAMPLE_MAX);
   assign under = quot < iir3_pkg::QUOT_BITS'(iir3_pkg::SAMPLE_MIN);

   always_comb begin
      if (over) begin
         sample = iir3_pkg::SAMPLE_BITS'(iir3_pkg::SAMPLE_MAX);
      end else if (under) begin
         sample = iir3_pkg::SAMPLE_BITS'(iir3_pkg::SAMPLE_MIN);
      end else begin
         sample = quot[iir3_pkg::SAMPLE_BITS-1:0];
      end
   end

   assign clipped = over | under;

endmodule

/* hw/rtl/iir_third_order_filter.sv */
// Top level of the third-order direct-form-1 IIR filter with coefficient registers.
// Each transferred sample is filtered combinationally: the current input and two rows of three
// tap cells (past inputs, past outputs) feed seven parallel 16x24 multiplies into one adder,
// the sum is rounded on the Q3.20 point, saturated to 16 bits, and registered as the result;
// the saturated value also shifts into the output-history row. A new sample is taken every
// cycle while the result register is empty or being drained, so the sustained rate is one
// sample per clock while rsp_ready stays high; the result is valid in the cycle after the
// input transfer. The feedback loop (output-history tap value through one multiply and the
// adder back into the output history) sets the clock limit. Coefficients reset to a
// pass-through gain of 1.0; writes to index 7 are ignored.
module iir_third_order_filter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [iir3_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [iir3_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                                   rsp_clipped,
   input  logic                                   csr_wr_en,
   input  logic [iir3_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic signed [iir3_pkg::COEF_BITS-1:0]   csr_wr_data
);

   iir3_pkg::coef_type   coef_ff [iir3_pkg::NUM_COEFS];
   iir3_pkg::coef_type   coef_in [iir3_pkg::NUM_COEFS];
   iir3_pkg::prod_type   ff_product [iir3_pkg::ORDER+1];
   iir3_pkg::prod_type   fb_product [iir3_pkg::ORDER];
   iir3_pkg::sample_type x_tap [iir3_pkg::ORDER];
   iir3_pkg::sample_type y_tap [iir3_pkg::ORDER];
   iir3_pkg::sample_type y_new;
   logic                 clip_new;
   logic                 advance;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   iir3_pkg::sample_type rsp_sample_ff;
   logic                 rsp_clipped_ff;

   // Coefficient registers
   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         unique case (iir3_pkg::coef_index_type'(csr_index))
            iir3_pkg::COEF_INPUT_NOW:
               coef_in[iir3_pkg::COEF_INPUT_NOW] = csr_wr_data;
            iir3_pkg::COEF_INPUT_PREV1:
               coef_in[iir3_pkg::COEF_INPUT_PREV1] = csr_wr_data;
            iir3_pkg::COEF_INPUT_PREV2:
               coef_in[iir3_pkg::COEF_INPUT_PREV2] = csr_wr_data;
            iir3_pkg::COEF_INPUT_PREV3:
               coef_in[iir3_pkg::COEF_INPUT_PREV3] = csr_wr_data;
            iir3_pkg::COEF_OUTPUT_PREV1:
               coef_in[iir3_pkg::COEF_OUTPUT_PREV1] = csr_wr_data;
            iir3_pkg::COEF_OUTPUT_PREV2:
               coef_in[iir3_pkg::COEF_OUTPUT_PREV2] = csr_wr_data;
            iir3_pkg::COEF_OUTPUT_PREV3:
               coef_in[iir3_pkg::COEF_OUTPUT_PREV3] = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < iir3_pkg::NUM_COEFS; i++) begin
            coef_ff[i] <= (i == int'(iir3_pkg::COEF_INPUT_NOW)) ? iir3_pkg::COEF_UNITY : '0;
         end
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Take a sample whenever the result register is free or drains this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid && req_ready;

   assign ff_product[0] = iir3_pkg::PROD_BITS'(req_sample_in) *
                          iir3_pkg::PROD_BITS'(coef_ff[iir3_pkg::COEF_INPUT_NOW]);

   for (genvar k = 0; k < iir3_pkg::ORDER; k++) begin : g_taps
      iir3_tap_cell u_x_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tap_in  ((k == 0) ? req_sample_in : x_tap[(k == 0) ? 0 : k-1]),
         .coef    (coef_ff[k+1]),
         .tap_out (x_tap[k]),
         .product (ff_product[k+1])
      );

      iir3_tap_cell u_y_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tap_in  ((k == 0) ? y_new : y_tap[(k == 0) ? 0 : k-1]),
         .coef    (coef_ff[k+1+iir3_pkg::ORDER]),
         .tap_out (y_tap[k]),
         .product (fb_product[k])
      );
   end

   iir3_accum u_accum (
      .ff_product (ff_product),
      .fb_product (fb_product),
      .sample     (y_new),
      .clipped    (clip_new)
   );

   // Result register: load on input transfer, drop on output transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_sample_ff  <= y_new;
         rsp_clipped_ff <= clip_new;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

endmodule
